// ----- rtl/core/ethp_pkg.sv -----
// ----------------------------------------------------------------------------
// ethp_pkg
// Shared types, tag codes and helpers for the term-format header parser.
// ----------------------------------------------------------------------------
package ethp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_TAGS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ORDER = 1'd1;

    // type tags
    localparam logic [7:0] TAG_NEW_FLOAT   = 8'd70;
    localparam logic [7:0] TAG_SMALL_INT   = 8'd97;
    localparam logic [7:0] TAG_INTEGER     = 8'd98;
    localparam logic [7:0] TAG_FLOAT_TEXT  = 8'd99;
    localparam logic [7:0] TAG_ATOM        = 8'd100;
    localparam logic [7:0] TAG_SMALL_TUPLE = 8'd104;
    localparam logic [7:0] TAG_LARGE_TUPLE = 8'd105;
    localparam logic [7:0] TAG_NIL         = 8'd106;
    localparam logic [7:0] TAG_STRING      = 8'd107;
    localparam logic [7:0] TAG_LIST        = 8'd108;
    localparam logic [7:0] TAG_BINARY      = 8'd109;
    localparam logic [7:0] TAG_SMALL_BIG   = 8'd110;
    localparam logic [7:0] TAG_LARGE_BIG   = 8'd111;

    localparam logic [31:0] FLOAT_TEXT_BYTES = 32'd31;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TAG     = 2'd1,
        PH_HEADER  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_VERSION = 3'd0,
        ROLE_TAG     = 3'd1,
        ROLE_HEADER  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_IGNORED = 3'd4
    } t_role;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_BIGNUM  = 2'd2,
        ERR_OUTSIDE = 2'd3
    } t_err;

    typedef struct packed {
        logic check_tags;
        logic swap_field_order;
    } t_cfg;

    typedef struct packed {
        t_role       byte_role;
        logic [7:0]  type_tag;
        logic [63:0] field_value;
        logic        value_valid;
        logic        term_done;
        t_err        error_code;
    } t_result;

    // header bytes that follow a tag; zero for tags without a header
    function automatic logic [3:0] header_len(input logic [7:0] tag);
        logic [3:0] len;
        len = 4'd0;
        case (tag)
            TAG_SMALL_INT, TAG_SMALL_TUPLE:                      len = 4'd1;
            TAG_ATOM, TAG_STRING:                                len = 4'd2;
            TAG_INTEGER, TAG_LARGE_TUPLE, TAG_LIST, TAG_BINARY:  len = 4'd4;
            TAG_NEW_FLOAT:                                       len = 4'd8;
            default:                                             len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic known_tag(input logic [7:0] tag);
        return ((tag >= TAG_SMALL_INT) && (tag <= TAG_ATOM)) ||
               ((tag >= TAG_SMALL_TUPLE) && (tag <= TAG_LARGE_BIG)) ||
               (tag == TAG_NEW_FLOAT);
    endfunction

endpackage

// ----- rtl/core/ethp_if.sv -----
// ----------------------------------------------------------------------------
// ethp_if
// Valid/ready channels: input bytes, parse results, register writes.
// ----------------------------------------------------------------------------
interface ethp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       msg_start;

    modport source (output valid, output byte_in, output msg_start, input ready);
    modport sink   (input valid, input byte_in, input msg_start, output ready);
endinterface

interface ethp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  type_tag;
    logic [63:0] field_value;
    logic        value_valid;
    logic        term_done;
    logic [1:0]  error_code;

    modport source (output valid, output byte_role, output type_tag, output field_value,
                    output value_valid, output term_done, output error_code, input ready);
    modport sink   (input valid, input byte_role, input type_tag, input field_value,
                    input value_valid, input term_done, input error_code, output ready);
endinterface

interface ethp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [0:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/external_term_header_parser.sv -----
// ----------------------------------------------------------------------------
// external_term_header_parser
// Byte-serial header parser for the external term format.
// ----------------------------------------------------------------------------
//  channel  dir  carries                                    handshake
//  i_in     in   byte_in, msg_start                         valid/ready
//  o_out    out  byte_role, type_tag, field_value,          valid/ready
//                value_valid, term_done, error_code
//  i_cfg    in   index (0 check_tags, 1 swap_field_order),  valid/ready
//                data
//
//  One byte per cycle unless stalled; each byte yields one result next cycle.
//  The parser state updates in the accept cycle and the result lands in a
//  single output register, so throughput is set by that register alone.
//  i_in.ready drops only while the output register is full and not drained.
//  Synchronous active-low reset: parser idle, check_tags 1, swap_field_order 0.
//  Register writes are always taken.
// ----------------------------------------------------------------------------
module external_term_header_parser
    import ethp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ethp_in_if.sink     i_in,
    ethp_out_if.source  o_out,
    ethp_cfg_if.sink    i_cfg
);

    t_cfg    cfg;
    t_result result;
    logic    out_free;
    logic    accept;

    assign i_in.ready = out_free;
    assign accept     = i_in.valid && out_free;

    ethp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // tag decode, header assembly and payload counting
    ethp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.byte_in),
        .i_start  (i_in.msg_start),
        .i_cfg    (cfg),
        .o_result (result)
    );

    ethp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

// ----- rtl/core/ethp_cfg.sv -----
// ----------------------------------------------------------------------------
// ethp_cfg
// Configuration register file; writes always taken.
// ----------------------------------------------------------------------------
module ethp_cfg
    import ethp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ethp_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CHECK_TAGS: n_cfg.check_tags       = i_cfg.data[0];
                CFG_SWAP_ORDER: n_cfg.swap_field_order = i_cfg.data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_tags       <= 1'b1;
            r_cfg.swap_field_order <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ethp_parse.sv -----
// ----------------------------------------------------------------------------
// ethp_parse
// Parser state and the per-byte update; produces one result per byte.
// ----------------------------------------------------------------------------
module ethp_parse
    import ethp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase      r_phase,    n_phase;
    logic [7:0]  r_tag,      n_tag;
    logic [3:0]  r_hdr_left, n_hdr_left;
    logic [63:0] r_acc,      n_acc;
    logic [31:0] r_pay_left, n_pay_left;

    logic        is_bignum;
    logic        reject;
    logic [3:0]  new_hdr_len;
    logic        hdr_last;
    logic [2:0]  lane;
    logic [63:0] acc_hdr;
    logic [31:0] pay_len;
    logic [31:0] pay_dec;
    t_result     res;

    assign is_bignum   = (i_byte == TAG_SMALL_BIG) || (i_byte == TAG_LARGE_BIG);
    assign reject      = i_cfg.check_tags && !known_tag(i_byte);
    assign new_hdr_len = header_len(i_byte);
    assign hdr_last    = (r_hdr_left == 4'd1);
    // byte position for little-endian assembly
    assign lane        = 3'(header_len(r_tag) - r_hdr_left);
    assign pay_dec     = r_pay_left - 32'd1;

    always_comb begin
        acc_hdr = {r_acc[55:0], i_byte};
        if (i_cfg.swap_field_order) begin
            acc_hdr = r_acc;
            for (int k = 0; k < 8; k++) begin
                if (lane == 3'(k)) begin
                    acc_hdr[8*k +: 8] = r_acc[8*k +: 8] | i_byte;
                end
            end
        end
    end

    always_comb begin
        case (r_tag)
            TAG_ATOM, TAG_STRING: pay_len = {16'd0, acc_hdr[15:0]};
            TAG_BINARY:           pay_len = acc_hdr[31:0];
            default:              pay_len = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_start) begin
            n_phase = PH_TAG;
        end else begin
            unique case (r_phase)
                PH_TAG: begin
                    if (is_bignum || reject)               n_phase = PH_IDLE;
                    else if (i_byte == TAG_FLOAT_TEXT)      n_phase = PH_PAYLOAD;
                    else if (new_hdr_len != 4'd0)           n_phase = PH_HEADER;
                    else                                    n_phase = PH_TAG;
                end
                PH_HEADER: begin
                    if (hdr_last) n_phase = (pay_len != 32'd0) ? PH_PAYLOAD : PH_TAG;
                end
                PH_PAYLOAD: begin
                    if (pay_dec == 32'd0) n_phase = PH_TAG;
                end
                PH_IDLE:  n_phase = PH_IDLE;
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_tag      = r_tag;
        n_hdr_left = r_hdr_left;
        n_acc      = r_acc;
        n_pay_left = r_pay_left;

        res.byte_role   = ROLE_IGNORED;
        res.field_value = 64'd0;
        res.value_valid = 1'b0;
        res.term_done   = 1'b0;
        res.error_code  = ERR_NONE;

        if (i_start) begin
            res.byte_role = ROLE_VERSION;
            n_tag         = 8'd0;
            n_hdr_left    = 4'd0;
            n_acc         = 64'd0;
            n_pay_left    = 32'd0;
        end else begin
            unique case (r_phase)
                PH_TAG: begin
                    res.byte_role = ROLE_TAG;
                    n_tag         = i_byte;
                    n_acc         = 64'd0;
                    n_pay_left    = 32'd0;
                    if (is_bignum) begin
                        res.error_code = ERR_BIGNUM;
                    end else if (reject) begin
                        res.error_code = ERR_UNKNOWN;
                    end else if (i_byte == TAG_FLOAT_TEXT) begin
                        n_pay_left = FLOAT_TEXT_BYTES;
                    end else begin
                        n_hdr_left = new_hdr_len;
                        if (new_hdr_len == 4'd0) res.term_done = 1'b1;
                    end
                end
                PH_HEADER: begin
                    res.byte_role = ROLE_HEADER;
                    n_acc         = acc_hdr;
                    n_hdr_left    = r_hdr_left - 4'd1;
                    if (hdr_last) begin
                        res.value_valid = 1'b1;
                        res.field_value = acc_hdr;
                        n_pay_left      = pay_len;
                        if (pay_len == 32'd0) res.term_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    res.byte_role = ROLE_PAYLOAD;
                    n_pay_left    = pay_dec;
                    if (pay_dec == 32'd0) res.term_done = 1'b1;
                end
                default: begin
                    res.byte_role  = ROLE_IGNORED;
                    res.error_code = ERR_OUTSIDE;
                end
            endcase
        end
        res.type_tag = n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tag      <= 8'd0;
            r_hdr_left <= 4'd0;
            r_acc      <= 64'd0;
            r_pay_left <= 32'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_tag      <= n_tag;
            r_hdr_left <= n_hdr_left;
            r_acc      <= n_acc;
            r_pay_left <= n_pay_left;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/core/ethp_out.sv -----
// ----------------------------------------------------------------------------
// ethp_out
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module ethp_out
    import ethp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_free,
    ethp_out_if.source  o_out
);

    logic    r_valid;
    t_result r_result;

    // slot is free when empty or draining this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.byte_role   = r_result.byte_role;
    assign o_out.type_tag    = r_result.type_tag;
    assign o_out.field_value = r_result.field_value;
    assign o_out.value_valid = r_result.value_valid;
    assign o_out.term_done   = r_result.term_done;
    assign o_out.error_code  = r_result.error_code;

endmodule
